// ----- rtl/pid_aw_pkg.sv -----
// Package for the PID controller with integrator clamp.
// Holds the fixed-point format, register indexes and saturating helpers.
// No dependencies.
`timescale 1ns / 1ps

package pid_aw_pkg;

    // Fixed-point format: signed values with FB fraction bits in VW bits.
    localparam int FB = 16;
    localparam int VW = 32;
    // Width of the time step field (unsigned).
    localparam int DT_W = 32;
    // Width of the scaled dividend and of the quotient.
    localparam int QW = VW + FB;
    // Width of the division step counter.
    localparam int CNT_W = $clog2(QW + 1);

    localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};

    // Configuration register indexes.
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_TARGET     = 3'd0;
    localparam logic [IDX_W-1:0] REG_KP         = 3'd1;
    localparam logic [IDX_W-1:0] REG_KI         = 3'd2;
    localparam logic [IDX_W-1:0] REG_KD         = 3'd3;
    localparam logic [IDX_W-1:0] REG_INT_FLOOR  = 3'd4;
    localparam logic [IDX_W-1:0] REG_INT_CEIL   = 3'd5;
    localparam logic [IDX_W-1:0] REG_DRV_FLOOR  = 3'd6;
    localparam logic [IDX_W-1:0] REG_DRV_CEIL   = 3'd7;

    // Shared multiplier operation selects.
    localparam logic [1:0] MUL_P  = 2'd0;
    localparam logic [1:0] MUL_ED = 2'd1;
    localparam logic [1:0] MUL_I  = 2'd2;
    localparam logic [1:0] MUL_D  = 2'd3;

    // Saturating signed add.
    function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
        logic signed [VW:0] s;
        begin
            s = {a[VW-1], a} + {b[VW-1], b};
            if (s[VW] != s[VW-1])
                return s[VW] ? V_MIN : V_MAX;
            return s[VW-1:0];
        end
    endfunction

    // Saturating signed subtract.
    function automatic logic signed [VW-1:0] sat_sub(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
        logic signed [VW:0] s;
        begin
            s = {a[VW-1], a} - {b[VW-1], b};
            if (s[VW] != s[VW-1])
                return s[VW] ? V_MIN : V_MAX;
            return s[VW-1:0];
        end
    endfunction

    // Raise to the floor first, then cut to the ceiling.
    function automatic logic signed [VW-1:0] clamp(input logic signed [VW-1:0] x,
                                                   input logic signed [VW-1:0] lo,
                                                   input logic signed [VW-1:0] hi);
        logic signed [VW-1:0] y;
        begin
            y = (x < lo) ? lo : x;
            if (y > hi)
                y = hi;
            return y;
        end
    endfunction

    // Magnitude of a signed value one bit wider than a value word.
    function automatic logic [VW-1:0] mag(input logic signed [VW:0] x);
        logic [VW:0] m;
        begin
            m = x[VW] ? (~x + 1'b1) : x;
            return m[VW-1:0];
        end
    endfunction

    // Put the sign on a magnitude and saturate to the value range.
    function automatic logic signed [VW-1:0] apply_sign(input logic [2*VW-1:0] q,
                                                        input logic neg);
        logic [2*VW-1:0] lim_neg;
        logic [2*VW-1:0] lim_pos;
        begin
            lim_neg = {{VW{1'b0}}, 1'b1, {(VW-1){1'b0}}};
            lim_pos = {{(VW+1){1'b0}}, {(VW-1){1'b1}}};
            if (neg)
                return (q > lim_neg) ? V_MIN : (~q[VW-1:0] + 1'b1);
            return (q > lim_pos) ? V_MAX : q[VW-1:0];
        end
    endfunction

endpackage

// ----- rtl/pid_controller_antiwindup.sv -----
// PID controller with integrator clamp, top level.
// Uses pid_aw_pkg for the number format, register indexes and helpers.
`timescale 1ns / 1ps

// Usage:
// Each input word on the s_ group carries a measurement, a time step and a
// clear-integral flag; each output word on the m_ group carries the clamped
// drive. Gains, setpoint and limits are written through cfg_we, cfg_index
// and cfg_data while the block is idle; a write takes effect at once.
// One word is worked at a time. The time step sets the path: the restoring
// divider for the derivative, which produces one quotient bit a cycle over 48
// bits, runs only with a nonzero time step, and with a zero time step the
// derivative term is zero. The single 32 x 32 multiplier serves all four
// products, each through a load step, a product step and a finish step.
// s_tready is high only while the sequencer is idle, so a new word is taken
// only after the last one has moved into the result register.
// The result register parts the two sides: a new word is accepted while a
// result still waits, and the finished next result waits until the register
// is taken.
// Reset clears the kept error and the accumulation to zero, the gains and
// setpoint to zero and the limits to the widest range, and empties the
// output register.
module pid_controller_antiwindup (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input words.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,  // measured_value, time_step
    input  logic                          s_tuser,  // clear_integral
    // Result words.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,  // drive_value
    // Configuration writes.
    input  logic                          cfg_we,
    input  logic [pid_aw_pkg::IDX_W-1:0]  cfg_index,
    input  logic [31:0]                   cfg_data
);
    import pid_aw_pkg::*;

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ERR     = 4'd1;
    localparam logic [3:0] S_DIFF    = 4'd2;
    localparam logic [3:0] S_MUL_LD  = 4'd3;
    localparam logic [3:0] S_MUL_PRD = 4'd4;
    localparam logic [3:0] S_MUL_FIN = 4'd5;
    localparam logic [3:0] S_ACC     = 4'd6;
    localparam logic [3:0] S_DIV     = 4'd7;
    localparam logic [3:0] S_DIV_FIN = 4'd8;
    localparam logic [3:0] S_SUM1    = 4'd9;
    localparam logic [3:0] S_SUM2    = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0]             state_reg;
    logic [1:0]             mul_sel_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   out_valid_reg;

    // Configuration registers.
    logic signed [VW-1:0]   target_reg;
    logic signed [VW-1:0]   kp_reg;
    logic signed [VW-1:0]   ki_reg;
    logic signed [VW-1:0]   kd_reg;
    logic signed [VW-1:0]   int_floor_reg;
    logic signed [VW-1:0]   int_ceil_reg;
    logic signed [VW-1:0]   drv_floor_reg;
    logic signed [VW-1:0]   drv_ceil_reg;

    // Kept controller state.
    logic signed [VW-1:0]   prev_err_reg;
    logic signed [VW-1:0]   acc_st_reg;

    // Working registers of one word.
    logic signed [VW-1:0]   meas_reg;
    logic [DT_W-1:0]        dt_reg;
    logic                   clr_reg;
    logic signed [VW-1:0]   err_reg;
    logic signed [VW-1:0]   diff_reg;
    logic signed [VW-1:0]   p_reg;
    logic signed [VW-1:0]   ed_reg;
    logic signed [VW-1:0]   i_reg;
    logic signed [VW-1:0]   quot_reg;
    logic signed [VW-1:0]   d_reg;
    logic signed [VW-1:0]   drive_reg;
    logic signed [VW-1:0]   out_reg;

    // Shared multiplier registers.
    logic [VW-1:0]          mul_a_reg;
    logic [VW-1:0]          mul_b_reg;
    logic                   mul_neg_reg;
    logic [2*VW-1:0]        prod_reg;

    // Divider registers: the dividend shifts out while quotient bits shift in.
    logic [QW-1:0]          num_reg;
    logic [DT_W-1:0]        rem_reg;

    logic                   in_fire;
    logic                   out_load;
    logic signed [VW-1:0]   op_a;
    logic signed [VW:0]     op_b;
    logic signed [VW-1:0]   mul_res;
    logic signed [VW-1:0]   acc_new;
    logic [DT_W:0]          rem_try;
    logic                   rem_ge;
    logic [DT_W:0]          rem_sub;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (mul_sel_reg)
            MUL_P:
            begin
                op_a = kp_reg;
                op_b = {err_reg[VW-1], err_reg};
            end
            MUL_ED:
            begin
                op_a = err_reg;
                op_b = {1'b0, dt_reg};
            end
            MUL_I:
            begin
                op_a = ki_reg;
                op_b = {acc_st_reg[VW-1], acc_st_reg};
            end
            default:
            begin
                op_a = kd_reg;
                op_b = {quot_reg[VW-1], quot_reg};
            end
        endcase
    end

    // Product rescaled by the fraction bits and saturated.
    assign mul_res = apply_sign(prod_reg >> FB, mul_neg_reg);

    // New accumulation, clamped to the anti-windup limits.
    assign acc_new = clamp(sat_add(ed_reg, clr_reg ? '0 : acc_st_reg),
                           int_floor_reg, int_ceil_reg);

    // One restoring division step.
    assign rem_try = {rem_reg, num_reg[QW-1]};
    assign rem_ge  = (rem_try >= {1'b0, dt_reg});
    assign rem_sub = rem_try - {1'b0, dt_reg};

    // Sequencer, configuration and kept state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_sel_reg   <= MUL_P;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            int_floor_reg <= V_MIN;
            int_ceil_reg  <= V_MAX;
            drv_floor_reg <= V_MIN;
            drv_ceil_reg  <= V_MAX;
            prev_err_reg  <= '0;
            acc_st_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TARGET:    target_reg    <= cfg_data;
                    REG_KP:        kp_reg        <= cfg_data;
                    REG_KI:        ki_reg        <= cfg_data;
                    REG_KD:        kd_reg        <= cfg_data;
                    REG_INT_FLOOR: int_floor_reg <= cfg_data;
                    REG_INT_CEIL:  int_ceil_reg  <= cfg_data;
                    REG_DRV_FLOOR: drv_floor_reg <= cfg_data;
                    REG_DRV_CEIL:  drv_ceil_reg  <= cfg_data;
                    default:       ;
                endcase
            end

            // The result register empties when taken and fills from the sequencer.
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                        state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    prev_err_reg <= err_reg;
                    mul_sel_reg  <= MUL_P;
                    state_reg    <= S_MUL_LD;
                end
                S_MUL_LD:
                begin
                    state_reg <= S_MUL_PRD;
                end
                S_MUL_PRD:
                begin
                    state_reg <= S_MUL_FIN;
                end
                S_MUL_FIN:
                begin
                    case (mul_sel_reg)
                        MUL_P:
                        begin
                            mul_sel_reg <= MUL_ED;
                            state_reg   <= S_MUL_LD;
                        end
                        MUL_ED:
                        begin
                            state_reg <= S_ACC;
                        end
                        MUL_I:
                        begin
                            cnt_reg   <= QW[CNT_W-1:0];
                            state_reg <= (dt_reg != '0) ? S_DIV : S_SUM1;
                        end
                        default:
                        begin
                            state_reg <= S_SUM1;
                        end
                    endcase
                end
                S_ACC:
                begin
                    acc_st_reg  <= acc_new;
                    mul_sel_reg <= MUL_I;
                    state_reg   <= S_MUL_LD;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == {{(CNT_W-1){1'b0}}, 1'b1})
                        state_reg <= S_DIV_FIN;
                end
                S_DIV_FIN:
                begin
                    mul_sel_reg <= MUL_D;
                    state_reg   <= S_MUL_LD;
                end
                S_SUM1:
                begin
                    state_reg <= S_SUM2;
                end
                S_SUM2:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            meas_reg <= s_tdata[VW-1:0];
            dt_reg   <= s_tdata[63:32];
            clr_reg  <= s_tuser;
        end

        case (state_reg)
            S_ERR:
            begin
                err_reg <= sat_sub(target_reg, meas_reg);
            end
            S_DIFF:
            begin
                diff_reg <= sat_sub(err_reg, prev_err_reg);
            end
            S_MUL_LD:
            begin
                mul_a_reg   <= mag({op_a[VW-1], op_a});
                mul_b_reg   <= mag(op_b);
                mul_neg_reg <= op_a[VW-1] ^ op_b[VW];
            end
            S_MUL_PRD:
            begin
                prod_reg <= mul_a_reg * mul_b_reg;
            end
            S_MUL_FIN:
            begin
                case (mul_sel_reg)
                    MUL_P:   p_reg  <= mul_res;
                    MUL_ED:  ed_reg <= mul_res;
                    MUL_I:
                    begin
                        i_reg   <= mul_res;
                        d_reg   <= '0;
                        num_reg <= {mag({diff_reg[VW-1], diff_reg}), {FB{1'b0}}};
                        rem_reg <= '0;
                    end
                    default: d_reg  <= mul_res;
                endcase
            end
            S_DIV:
            begin
                num_reg <= {num_reg[QW-2:0], rem_ge};
                rem_reg <= rem_ge ? rem_sub[DT_W-1:0] : rem_try[DT_W-1:0];
            end
            S_DIV_FIN:
            begin
                quot_reg <= apply_sign({{(2*VW-QW){1'b0}}, num_reg}, diff_reg[VW-1]);
            end
            S_SUM1:
            begin
                p_reg <= sat_add(p_reg, i_reg);
            end
            S_SUM2:
            begin
                drive_reg <= clamp(sat_add(p_reg, d_reg), drv_floor_reg, drv_ceil_reg);
            end
            default:
            begin
            end
        endcase

        if (out_load)
            out_reg <= drive_reg;
    end

`ifndef ASSERT_OFF
    // An accepted word keeps the sequencer busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("input accepted twice in a row");

    // The division counter is never zero inside the divide state.
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg != '0))
        else $error("divider entered with an empty step count");

    // A newly stored accumulation does not pass the upper anti-windup limit.
    a_acc_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |=> (acc_st_reg <= int_ceil_reg))
        else $error("accumulation above its ceiling");

    // A waiting result is not overwritten by the next one.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !m_tready) |=> $stable(out_reg))
        else $error("waiting result overwritten");
`endif

endmodule

// ----- verif/pid_controller_antiwindup_tb.sv -----
// Self-checking testbench for pid_controller_antiwindup.
// Depends on pid_aw_pkg and the RTL top level; a scoreboard class predicts each drive word.
`timescale 1ns / 1ps

module pid_controller_antiwindup_tb;

    import pid_aw_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles with no handshake before giving up
    localparam int LONG_HOLD   = 300;   // receiver hold-off used to back the block up
    localparam int RAND_PHASES = 6;
    localparam int PHASE_WORDS = 100;
    localparam int MAX_REPORTS = 10;

    // Predicts the drive for every accepted word and checks the results in order.
    class drive_scoreboard;
        logic signed [31:0] regs [8];
        longint             last_error;
        longint             accumulation;
        logic [31:0]        pending_drives [$];
        int                 words_in;
        int                 results_checked;
        int                 failures;

        function void reset_state();
            foreach (regs[k])
                regs[k] = '0;
            regs[REG_INT_FLOOR] = V_MIN;
            regs[REG_INT_CEIL]  = V_MAX;
            regs[REG_DRV_FLOOR] = V_MIN;
            regs[REG_DRV_CEIL]  = V_MAX;
            last_error   = 0;
            accumulation = 0;
            pending_drives.delete();
        endfunction

        function void write_register(logic [IDX_W-1:0] idx, logic [31:0] val);
            regs[idx] = val;
        endfunction

        // Saturate to the signed value range.
        function longint sat_value(longint x);
            longint vmax;
            longint vmin;
            vmax = (longint'(1) << (VW - 1)) - 1;
            vmin = -vmax - 1;
            if (x > vmax)
                return vmax;
            if (x < vmin)
                return vmin;
            return x;
        endfunction

        // Put a sign on a magnitude, saturating to the value range.
        function longint signed_limit(logic [127:0] q, bit neg);
            logic [127:0] lim;
            lim = neg ? (128'd1 << (VW - 1)) : ((128'd1 << (VW - 1)) - 128'd1);
            if (q > lim)
                q = lim;
            return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
        endfunction

        // Fixed-point product, truncated toward zero.
        function longint fixed_mul(longint a, longint b);
            logic [63:0]  ma;
            logic [63:0]  mb;
            logic [127:0] q;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            q = ({64'd0, ma} * {64'd0, mb}) >> FB;
            return signed_limit(q, (a < 0) != (b < 0));
        endfunction

        // Fixed-point quotient by an unsigned nonzero time step.
        function longint fixed_div(longint n, logic [31:0] d);
            logic [63:0]  m;
            logic [127:0] q;
            m = (n < 0) ? -n : n;
            q = ({64'd0, m} << FB) / {96'd0, d};
            return signed_limit(q, n < 0);
        endfunction

        // Raise to the floor first, then cut to the ceiling.
        function longint bound(longint x, longint lo, longint hi);
            if (x < lo)
                x = lo;
            if (x > hi)
                x = hi;
            return x;
        endfunction

        function longint reg_val(logic [IDX_W-1:0] idx);
            return sat_value(longint'(regs[idx]));
        endfunction

        function logic [31:0] predict_drive(logic [31:0] meas, logic [31:0] dt, logic clr);
            longint meas_v;
            longint err;
            longint p_term;
            longint acc;
            longint i_term;
            longint d_term;
            longint sum;
            longint drv;
            meas_v = sat_value(longint'($signed(meas)));
            err    = sat_value(reg_val(REG_TARGET) - meas_v);
            p_term = fixed_mul(reg_val(REG_KP), err);
            acc    = sat_value(fixed_mul(err, longint'(dt)) + (clr ? 0 : accumulation));
            acc    = bound(acc, reg_val(REG_INT_FLOOR), reg_val(REG_INT_CEIL));
            i_term = fixed_mul(reg_val(REG_KI), acc);
            // A zero time step drops the derivative term.
            if (dt != 0)
                d_term = fixed_mul(reg_val(REG_KD), fixed_div(sat_value(err - last_error), dt));
            else
                d_term = 0;
            sum = sat_value(sat_value(p_term + i_term) + d_term);
            drv = bound(sum, reg_val(REG_DRV_FLOOR), reg_val(REG_DRV_CEIL));
            drv = bound(drv, -64'sd2147483648, 64'sd2147483647);
            last_error   = err;
            accumulation = acc;
            return drv[31:0];
        endfunction

        function void note_word(logic [31:0] meas, logic [31:0] dt, logic clr);
            pending_drives.push_back(predict_drive(meas, dt, clr));
            words_in++;
        endfunction

        function void check_word(logic [31:0] got);
            logic [31:0] want;
            results_checked++;
            if (pending_drives.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR: drive word %h arrived with no word outstanding", got);
            end
            else begin
                want = pending_drives.pop_front();
                if (want !== got) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("ERROR: drive result %0d: expected %h (%0d), got %h (%0d)",
                                 results_checked, want, $signed(want), got, $signed(got));
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_index;
    logic [31:0]          cfg_data;

    drive_scoreboard      sb;
    bit                   src_idle_on;
    bit                   snk_idle_on;
    bit                   long_hold_req;
    logic [31:0]          cur_target;
    int                   settings_loaded;
    int                   idle_cycles;

    pid_controller_antiwindup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Sample both handshakes at the rising edge and watch for a hung block.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_word(s_tdata[31:0], s_tdata[63:32], s_tuser);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
                $display("pid_controller_antiwindup_tb: done, errors");
                $finish;
            end
        end
    end

    // Result side: random stalls per word, plus one long hold-off on request.
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (long_hold_req) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
            end
            stall = snk_idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Random signed value with a random number of leading sign bits.
    function automatic logic [31:0] rand_scaled();
        logic signed [31:0] v;
        v = $signed($urandom);
        return v >>> $urandom_range(0, 31);
    endfunction

    function automatic logic [31:0] pick_gain();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? V_MAX : V_MIN;
        return rand_scaled();
    endfunction

    // Offer one input word after a random gap; returns at the falling edge after acceptance.
    task automatic send_word(input logic [31:0] meas, input logic [31:0] dt, input logic clr);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {dt, meas};
        s_tuser  = clr;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted drive has come back.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending_drives.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        sb.write_register(idx, val);
        @(negedge clk);
    endtask

    // Write all eight registers back to back; only called while the block is idle.
    task automatic apply_settings(input logic [31:0] target, input logic [31:0] kp,
                                  input logic [31:0] ki, input logic [31:0] kd,
                                  input logic [31:0] int_lo, input logic [31:0] int_hi,
                                  input logic [31:0] drv_lo, input logic [31:0] drv_hi);
        write_reg(REG_TARGET, target);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_INT_FLOOR, int_lo);
        write_reg(REG_INT_CEIL, int_hi);
        write_reg(REG_DRV_FLOOR, drv_lo);
        write_reg(REG_DRV_CEIL, drv_hi);
        cfg_we = 1'b0;
        cur_target = target;
        settings_loaded++;
    endtask

    // Random limit pair, usually ordered, sometimes crossed, sometimes the full range.
    task automatic rand_limits(output logic [31:0] lo, output logic [31:0] hi);
        logic [31:0] a;
        logic [31:0] b;
        a = rand_scaled();
        b = rand_scaled();
        if ($urandom_range(0, 3) == 0) begin
            lo = V_MIN;
            hi = V_MAX;
        end
        else if ($signed(a) > $signed(b) && $urandom_range(0, 5) != 0) begin
            lo = b;
            hi = a;
        end
        else begin
            lo = a;
            hi = b;
        end
    endtask

    task automatic load_random_settings();
        logic [31:0] int_lo;
        logic [31:0] int_hi;
        logic [31:0] drv_lo;
        logic [31:0] drv_hi;
        rand_limits(int_lo, int_hi);
        rand_limits(drv_lo, drv_hi);
        apply_settings(rand_scaled(), pick_gain(), pick_gain(), pick_gain(),
                       int_lo, int_hi, drv_lo, drv_hi);
    endtask

    // Mostly measurements near the setpoint, with a spread of time steps.
    task automatic send_random_word();
        logic [31:0] meas;
        logic [31:0] dt;
        int          pick;
        if ($urandom_range(0, 9) < 6)
            meas = cur_target - rand_scaled();
        else
            meas = $urandom;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            dt = '0;
        else if (pick == 1)
            dt = $urandom;
        else if (pick == 2)
            dt = $urandom_range(1, 16);
        else
            dt = $urandom_range(1, 32'h0004_0000);
        send_word(meas, dt, $urandom_range(0, 9) == 0);
    endtask

    // Main sequence.
    initial
    begin
        sb = new();
        sb.reset_state();
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_TARGET;
        cfg_data        = '0;
        src_idle_on     = 1'b1;
        snk_idle_on     = 1'b1;
        long_hold_req   = 1'b0;
        cur_target      = '0;
        settings_loaded = 0;
        idle_cycles     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values: zero gains, widest limits.
        send_word(32'h0001_0000, 32'h0001_0000, 1'b0);
        send_word(32'h8000_0000, 32'h0000_8000, 1'b0);
        send_word(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
        wait_drained();

        // Moderate gains: field extremes, zero and tiny time steps, clear.
        apply_settings(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0000_4000,
                       V_MIN, V_MAX, V_MIN, V_MAX);
        send_word(32'h0000_0000, 32'h0001_0000, 1'b0);
        send_word(32'h0000_8000, 32'h0000_8000, 1'b0);
        send_word(32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
        send_word(32'h8000_0000, 32'h0001_0000, 1'b0);
        send_word(32'h0001_0000, 32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_word(32'h1234_5678, 32'h0000_0001, 1'b0);
        send_word(32'h0000_0000, 32'h0001_0000, 1'b1);
        wait_drained();

        // Largest gains and most negative setpoint, to drive the terms into saturation.
        apply_settings(V_MIN, V_MAX, V_MAX, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX);
        send_word(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_word(32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        send_word(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_word(32'h8000_0000, 32'h0001_0000, 1'b1);
        send_word(32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
        wait_drained();

        // Most negative gains, floors above ceilings on both clamps.
        apply_settings(V_MAX, V_MIN, V_MIN, V_MIN, 32'h0010_0000, 32'hFFF0_0000,
                       32'h0100_0000, 32'hFF00_0000);
        send_word(32'h8000_0000, 32'h0001_0000, 1'b0);
        send_word(32'h0000_0000, 32'h0000_8000, 1'b0);
        send_word(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
        send_word(32'h0000_1000, 32'h0000_0100, 1'b0);
        wait_drained();

        // Random phases, each under fresh settings.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            load_random_settings();
            src_idle_on = (ph != 2);
            snk_idle_on = (ph != 2);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Back the block up behind a stalled receiver.
                if (ph == 3 && n == 40)
                    long_hold_req = 1'b1;
                // Let the pipeline run dry in the middle of a phase.
                if (ph == 4 && n == 50)
                    wait_drained();
                send_random_word();
            end
        end

        wait_drained();
        repeat (100) @(posedge clk);

        $display("Ran %0d words through %0d register settings (reset values, saturating gains,",
                 sb.words_in, settings_loaded);
        $display("crossed clamps, zero time steps, a long output stall); %0d drive words checked.",
                 sb.results_checked);
        if (sb.failures == 0 && sb.pending_drives.size() == 0)
            $display("pid_controller_antiwindup_tb: done, clean");
        else
            $display("pid_controller_antiwindup_tb: done, errors");
        $finish;
    end

endmodule
